>>> design/wilder_rsi_stream_top_assert.svh
// Assertion macros used by the RSI stream datapath.
// Needs clk and rst in the scope of each use.
`ifndef WILDER_RSI_STREAM_TOP_ASSERT_SVH
`define WILDER_RSI_STREAM_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define WRS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define WRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/wrs_pkg.sv
// Widths, constants, command and status types for the RSI stream block.
// No dependencies; imported by every module of the block.
package wrs_pkg;

  localparam int PRICE_W  = 32;
  localparam int MOVE_W   = 40;
  localparam int AVG_W    = 48;
  localparam int PERIOD_W = 8;
  localparam int RSI_W    = 15;
  localparam int PROD_W   = AVG_W + PERIOD_W;
  localparam int DVD_W    = AVG_W + RSI_W;
  localparam int DSR_W    = AVG_W + 1;

  localparam int MAX_PERIOD_DEFAULT = 255;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);
  localparam logic [RSI_W-1:0]    RSI_FULL     = RSI_W'(25600);

  typedef enum logic [1:0] {
    OP_GAIN,
    OP_LOSS,
    OP_RATIO
  } wrs_op_t;

  typedef struct packed {
    logic    capture;
    logic    prep;
    logic    mul;
    logic    div_start;
    wrs_op_t op;
    logic    set_full;
    logic    emit;
    logic    cfg_wr;
  } wrs_cmd_t;

  typedef struct packed {
    logic first;
    logic warm;
    logic reach;
    logic loss_zero;
    logic div_done;
    logic div_busy;
    logic out_free;
  } wrs_stat_t;

endpackage

>>> design/wilder_rsi_stream_top.sv
// Wilder RSI over a stream of Q24.8 prices: one Q7.8 result item per price item.
// An item that starts a series or only adds to the warm-up sums skips the
// divider; an item that completes warm-up or is smoothed runs three
// 63-step divisions (gain, loss, ratio) on one shared radix-2 divider, and
// skips the ratio division when the average loss is zero. The period register is
// written only while no item is in progress; cfg_ready shows that state.
// Depends on wrs_pkg, wrs_ctrl and wrs_dp.
module wilder_rsi_stream_top
  import wrs_pkg::*;
#(
  parameter int MAX_PERIOD = MAX_PERIOD_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [PRICE_W-1:0]  price,
  input  logic                first_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [RSI_W-1:0]    rsi,
  output logic                valid_res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PERIOD_W-1:0] cfg_data
);

  wrs_cmd_t  cmd;
  wrs_stat_t st;

  wrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cfg_valid (cfg_valid),
    .st        (st),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready)
  );

  wrs_dp #(
    .MAX_PERIOD (MAX_PERIOD)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .price        (price),
    .first_sample (first_sample),
    .cfg_data     (cfg_data),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .rsi          (rsi),
    .valid_res    (valid_res)
  );

endmodule

>>> design/wrs_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on wrs_pkg for the operand widths.
module wrs_div
  import wrs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [DVD_W-1:0] quo;
  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   trial_diff;
  logic             fit;

  assign trial      = {rem, quo[DVD_W-1]};
  assign trial_diff = trial - {1'b0, dsr};
  assign fit        = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(DVD_W - 1);
      end else if (running) begin
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (running) begin
      quo <= {quo[DVD_W-2:0], fit};
      rem <= fit ? trial_diff[DSR_W-1:0] : trial[DSR_W-1:0];
    end
  end

  assign busy     = running;
  assign quotient = quo;

endmodule

>>> design/wrs_ctrl.sv
// Sequencer for the RSI stream: steps each item through update, the divisions where needed, and output.
// Depends on wrs_pkg for the command and status types.
module wrs_ctrl
  import wrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      cfg_valid,
  input  wrs_stat_t st,
  output wrs_cmd_t  cmd,
  output logic      in_stall,
  output logic      cfg_ready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MUL_G,
    S_GO_G,
    S_WAIT_G,
    S_MUL_L,
    S_GO_L,
    S_WAIT_L,
    S_RATIO,
    S_WAIT_R,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.op     = OP_GAIN;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.cfg_wr  = cfg_valid;
        cmd.capture = in_valid;
        if (in_valid) state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (st.first || (st.warm && !st.reach)) state_next = S_EMIT;
        else state_next = S_MUL_G;
      end
      S_MUL_G: begin
        cmd.mul    = 1'b1;
        cmd.op     = OP_GAIN;
        state_next = S_GO_G;
      end
      S_GO_G: begin
        cmd.div_start = 1'b1;
        cmd.op        = OP_GAIN;
        state_next    = S_WAIT_G;
      end
      S_WAIT_G: begin
        if (st.div_done) state_next = S_MUL_L;
      end
      S_MUL_L: begin
        cmd.mul    = 1'b1;
        cmd.op     = OP_LOSS;
        state_next = S_GO_L;
      end
      S_GO_L: begin
        cmd.div_start = 1'b1;
        cmd.op        = OP_LOSS;
        state_next    = S_WAIT_L;
      end
      S_WAIT_L: begin
        if (st.div_done) state_next = S_RATIO;
      end
      S_RATIO: begin
        cmd.op = OP_RATIO;
        if (st.loss_zero) begin
          cmd.set_full = 1'b1;
          state_next   = S_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_WAIT_R;
        end
      end
      S_WAIT_R: begin
        if (st.div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

endmodule

>>> design/wrs_dp.sv
// Datapath of the RSI stream: series state, multiplier, divider, result register.
// Depends on wrs_pkg, wrs_div and the assertion macro header.
`include "wilder_rsi_stream_top_assert.svh"

module wrs_dp
  import wrs_pkg::*;
#(
  parameter int MAX_PERIOD = MAX_PERIOD_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  wrs_cmd_t            cmd,
  output wrs_stat_t           st,
  input  logic [PRICE_W-1:0]  price,
  input  logic                first_sample,
  input  logic [PERIOD_W-1:0] cfg_data,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [RSI_W-1:0]    rsi,
  output logic                valid_res
);

  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W-1:0] p_eff;
  logic [PERIOD_W-1:0] pm1;
  logic [PRICE_W-1:0]  prev_price;
  logic [PERIOD_W-1:0] moves_seen;
  logic [AVG_W-1:0]    gain_avg;
  logic [AVG_W-1:0]    loss_avg;
  logic [MOVE_W-1:0]   gain_mv;
  logic [MOVE_W-1:0]   loss_mv;
  logic                first_q;
  logic                smooth_q;
  logic [PROD_W-1:0]   prod;
  wrs_op_t             tgt;
  logic [RSI_W-1:0]    rsi_work;
  logic                flag_work;

  logic [PRICE_W:0]    diff;
  logic [PRICE_W:0]    diff_neg;
  logic [PRICE_W-1:0]  mag;
  logic [MOVE_W-1:0]   mv;
  logic                rising;
  logic [AVG_W:0]      sum_g;
  logic [AVG_W:0]      sum_l;
  logic [DVD_W-1:0]    dvd;
  logic [DSR_W-1:0]    dsr;
  logic [DVD_W-1:0]    quo;
  logic [AVG_W-1:0]    quo_sat;
  logic                div_busy;
  logic                div_done;

  always_comb begin
    if (period == '0) p_eff = PERIOD_W'(1);
    else if (32'(period) > MAX_PERIOD) p_eff = PERIOD_W'(MAX_PERIOD);
    else p_eff = period;
  end
  assign pm1 = p_eff - PERIOD_W'(1);

  assign diff     = {price[PRICE_W-1], price} - {prev_price[PRICE_W-1], prev_price};
  assign diff_neg = ~diff + (PRICE_W+1)'(1);
  assign rising   = !diff[PRICE_W] && (diff != '0);
  assign mag      = diff[PRICE_W] ? diff_neg[PRICE_W-1:0] : diff[PRICE_W-1:0];
  assign mv       = {mag, (MOVE_W-PRICE_W)'(0)};

  assign sum_g = (AVG_W+1)'(gain_avg) + (AVG_W+1)'(gain_mv);
  assign sum_l = (AVG_W+1)'(loss_avg) + (AVG_W+1)'(loss_mv);

  always_comb begin
    case (cmd.op)
      OP_GAIN: begin
        dvd = smooth_q ? DVD_W'(prod + PROD_W'(gain_mv)) : DVD_W'(gain_avg);
        dsr = DSR_W'(p_eff);
      end
      OP_LOSS: begin
        dvd = smooth_q ? DVD_W'(prod + PROD_W'(loss_mv)) : DVD_W'(loss_avg);
        dsr = DSR_W'(p_eff);
      end
      OP_RATIO: begin
        dvd = (DVD_W'(gain_avg) << 14) + (DVD_W'(gain_avg) << 13)
            + (DVD_W'(gain_avg) << 10);
        dsr = DSR_W'(gain_avg) + DSR_W'(loss_avg);
      end
      default: begin
        dvd = '0;
        dsr = DSR_W'(1);
      end
    endcase
  end

  wrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  assign quo_sat = (quo[DVD_W-1:AVG_W] != '0) ? '1 : quo[AVG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      period     <= PERIOD_RESET;
      prev_price <= '0;
      moves_seen <= '0;
      gain_avg   <= '0;
      loss_avg   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.cfg_wr) period <= cfg_data;
      if (cmd.capture) begin
        prev_price <= price;
        if (first_sample) begin
          moves_seen <= '0;
          gain_avg   <= '0;
          loss_avg   <= '0;
        end
      end
      if (cmd.prep && !first_q) begin
        if (st.warm) begin
          gain_avg   <= sum_g[AVG_W] ? '1 : sum_g[AVG_W-1:0];
          loss_avg   <= sum_l[AVG_W] ? '1 : sum_l[AVG_W-1:0];
          moves_seen <= moves_seen + PERIOD_W'(1);
        end else if (moves_seen != '1) begin
          moves_seen <= moves_seen + PERIOD_W'(1);
        end
      end
      if (div_done) begin
        case (tgt)
          OP_GAIN: gain_avg <= quo_sat;
          OP_LOSS: loss_avg <= quo_sat;
          default: ;
        endcase
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      first_q <= first_sample;
      gain_mv <= rising ? mv : '0;
      loss_mv <= rising ? '0 : mv;
    end
    if (cmd.prep) begin
      smooth_q  <= !st.warm;
      flag_work <= !first_q && (!st.warm || st.reach);
      rsi_work  <= '0;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(cmd.op == OP_LOSS ? loss_avg : gain_avg) * PROD_W'(pm1);
    end
    if (cmd.div_start) tgt <= cmd.op;
    if (div_done && tgt == OP_RATIO) rsi_work <= quo[RSI_W-1:0];
    if (cmd.set_full) rsi_work <= RSI_FULL;
    if (cmd.emit) begin
      rsi       <= rsi_work;
      valid_res <= flag_work;
    end
  end

  always_comb begin
    st.first     = first_q;
    st.warm      = moves_seen < p_eff;
    st.reach     = ((PERIOD_W+1)'(moves_seen) + (PERIOD_W+1)'(1)) == (PERIOD_W+1)'(p_eff);
    st.loss_zero = (loss_avg == '0);
    st.div_done  = div_done;
    st.div_busy  = div_busy;
    st.out_free  = !out_valid || !out_stall;
  end

  `WRS_ASSERT_SAME(a_rsi_range, out_valid, rsi <= RSI_FULL, "rsi above full scale")
  `WRS_ASSERT_SAME(a_warm_zero, out_valid && !valid_res, rsi == '0, "warm-up item with rsi")
  `WRS_ASSERT_SAME(a_div_idle, cmd.div_start, !div_busy, "divider restarted while busy")
  `WRS_ASSERT_NEXT(a_emit_shown, cmd.emit, out_valid && rsi == $past(rsi_work),
    "emitted item not shown")

endmodule
